[rtl/lfucp_pkg.sv]
// shared types and constants for the lfu cache replacement directory
package lfucp_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned BYTES_W = 21;
  localparam int unsigned SLOT_W  = 6;

  localparam logic [BYTES_W-1:0] CAP_RESET = 21'h10_0000;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_SET = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    KIND_HIT    = 3'd0,
    KIND_MISS   = 3'd1,
    KIND_EVICT  = 3'd2,
    KIND_STORE  = 3'd3,
    KIND_REJECT = 3'd4
  } kind_e;

endpackage

[rtl/lfucp_req_if.sv]
// request channel: get or set of one key
interface lfucp_req_if import lfucp_pkg::*; ();
  logic                valid;
  logic                ready;
  action_e             action;
  logic [KEY_W-1:0]    key_tag;
  logic [BYTES_W-1:0]  value_bytes;

  modport source (output valid, action, key_tag, value_bytes, input ready);
  modport sink   (input valid, action, key_tag, value_bytes, output ready);
endinterface

[rtl/lfucp_rsp_if.sv]
// result channel: hit, miss, eviction, store or reject
interface lfucp_rsp_if import lfucp_pkg::*; ();
  logic                valid;
  logic                ready;
  kind_e               kind;
  logic [SLOT_W-1:0]   slot_index;
  logic [KEY_W-1:0]    key_out;
  logic [BYTES_W-1:0]  size_out;
  logic [BYTES_W-1:0]  bytes_in_use;
  logic                last;

  modport source (output valid, kind, slot_index, key_out, size_out, bytes_in_use, last,
                  input ready);
  modport sink   (input valid, kind, slot_index, key_out, size_out, bytes_in_use, last,
                  output ready);
endinterface

[rtl/lfu_cache_policy_byte_budget.sv]
// lfu replacement directory with byte budget, one entry memory scanned by a sequencer
// a get scans the entry memory once; one request is handled at a time
// a set scans once plus once more per eviction, each scan reading one
// slot per cycle through the single read port of the entry memory
// a rejected set skips the scans; results leave through an output register
// reset clears valid bits, byte total and state; capacity resets to 1048576, no clear pass
module lfu_cache_policy_byte_budget import lfucp_pkg::*; #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [BYTES_W-1:0]  cfg_wdata_i,
  lfucp_req_if.sink           req_i,
  lfucp_rsp_if.source         rsp_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(SLOTS);

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [BYTES_W-1:0]    size;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_REJECT, S_FIND, S_FOUND, S_CHECK, S_MIN, S_EVICT, S_STORE
  } state_e;

  state_e               state_q;
  logic [BYTES_W-1:0]   cap_q;
  logic [BYTES_W-1:0]   total_q;
  logic [SLOTS-1:0]     valid_q;

  action_e              act_q;
  logic [KEY_W-1:0]     key_q;
  logic [BYTES_W-1:0]   vb_q;

  logic [CNT_W-1:0]     scan_q;
  logic                 rd_live_q;
  logic [IDX_W-1:0]     rd_idx_q;
  entry_t               rd_data_q;

  logic                 hit_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic [BYTES_W-1:0]   hit_size_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;

  logic                 free_ok_q;
  logic [IDX_W-1:0]     free_idx_q;

  logic                 best_ok_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [COUNT_BITS-1:0] best_cnt_q;
  logic [KEY_W-1:0]     best_key_q;
  logic [BYTES_W-1:0]   best_size_q;

  logic                 out_vld_q;
  kind_e                out_kind_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic [KEY_W-1:0]     out_key_q;
  logic [BYTES_W-1:0]   out_size_q;
  logic [BYTES_W-1:0]   out_bytes_q;
  logic                 out_last_q;

  entry_t               mem_q [SLOTS];
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  entry_t               mem_wdata;

  logic                 out_free;
  logic [BYTES_W:0]     fit_sum;
  logic                 fits;
  logic [BYTES_W-1:0]   total_evict;
  logic [BYTES_W-1:0]   total_store;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign out_free    = !out_vld_q || rsp_o.ready;
  assign fit_sum     = {1'b0, total_q} + {1'b0, vb_q};
  assign fits        = fit_sum <= {1'b0, cap_q};
  assign total_evict = total_q - best_size_q;
  assign total_store = total_q + vb_q;
  assign cnt_inc     = (&hit_cnt_q) ? hit_cnt_q : hit_cnt_q + COUNT_BITS'(1);

  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.kind         = out_kind_q;
  assign rsp_o.slot_index   = out_slot_q;
  assign rsp_o.key_out      = out_key_q;
  assign rsp_o.size_out     = out_size_q;
  assign rsp_o.bytes_in_use = out_bytes_q;
  assign rsp_o.last         = out_last_q;

  // single write port: count bump on a get hit, new entry on a store
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx_q;
    mem_wdata = '{key: key_q, size: vb_q, count: COUNT_BITS'(1)};
    if (state_q == S_FOUND && act_q == ACT_GET && hit_q && out_free) begin
      mem_we    = 1'b1;
      mem_waddr = hit_idx_q;
      mem_wdata = '{key: key_q, size: hit_size_q, count: cnt_inc};
    end else if (state_q == S_STORE && out_free) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[scan_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      total_q     <= '0;
      valid_q     <= '0;
      act_q       <= ACT_GET;
      key_q       <= '0;
      vb_q        <= '0;
      scan_q      <= '0;
      rd_live_q   <= 1'b0;
      rd_idx_q    <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_size_q  <= '0;
      hit_cnt_q   <= '0;
      free_ok_q   <= 1'b0;
      free_idx_q  <= '0;
      best_ok_q   <= 1'b0;
      best_idx_q  <= '0;
      best_cnt_q  <= '0;
      best_key_q  <= '0;
      best_size_q <= '0;
      out_vld_q   <= 1'b0;
      out_kind_q  <= KIND_MISS;
      out_slot_q  <= '0;
      out_key_q   <= '0;
      out_size_q  <= '0;
      out_bytes_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      rd_live_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            act_q     <= req_i.action;
            key_q     <= req_i.key_tag;
            vb_q      <= req_i.value_bytes;
            scan_q    <= '0;
            hit_q     <= 1'b0;
            free_ok_q <= 1'b0;
            if (req_i.action == ACT_SET && req_i.value_bytes > cap_q) begin
              state_q <= S_REJECT;
            end else begin
              state_q <= S_FIND;
            end
          end
        end

        S_REJECT: begin
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_kind_q  <= KIND_REJECT;
            out_slot_q  <= '0;
            out_key_q   <= key_q;
            out_size_q  <= vb_q;
            out_bytes_q <= total_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        // tag match and lowest free slot, one slot per cycle
        S_FIND: begin
          if (scan_q != SCAN_END) begin
            scan_q    <= scan_q + CNT_W'(1);
            rd_live_q <= 1'b1;
            rd_idx_q  <= scan_q[IDX_W-1:0];
          end else if (!rd_live_q) begin
            state_q <= S_FOUND;
          end
          if (rd_live_q) begin
            if (valid_q[rd_idx_q] && rd_data_q.key == key_q) begin
              hit_q      <= 1'b1;
              hit_idx_q  <= rd_idx_q;
              hit_size_q <= rd_data_q.size;
              hit_cnt_q  <= rd_data_q.count;
            end
            if (!valid_q[rd_idx_q] && !free_ok_q) begin
              free_ok_q  <= 1'b1;
              free_idx_q <= rd_idx_q;
            end
          end
        end

        S_FOUND: begin
          if (act_q == ACT_GET) begin
            if (out_free) begin
              out_vld_q   <= 1'b1;
              out_kind_q  <= hit_q ? KIND_HIT : KIND_MISS;
              out_slot_q  <= hit_q ? SLOT_W'(hit_idx_q) : '0;
              out_key_q   <= key_q;
              out_size_q  <= hit_q ? hit_size_q : '0;
              out_bytes_q <= total_q;
              out_last_q  <= 1'b1;
              state_q     <= S_IDLE;
            end
          end else begin
            // a set of a present key silently drops the old entry
            if (hit_q) begin
              valid_q[hit_idx_q] <= 1'b0;
              total_q            <= total_q - hit_size_q;
              if (!free_ok_q || hit_idx_q < free_idx_q) begin
                free_ok_q  <= 1'b1;
                free_idx_q <= hit_idx_q;
              end
            end
            state_q <= S_CHECK;
          end
        end

        S_CHECK: begin
          if ((free_ok_q && fits) || !(|valid_q)) begin
            state_q <= S_STORE;
          end else begin
            scan_q    <= '0;
            best_ok_q <= 1'b0;
            state_q   <= S_MIN;
          end
        end

        // lowest count among valid slots, strict compare keeps the lowest index
        S_MIN: begin
          if (scan_q != SCAN_END) begin
            scan_q    <= scan_q + CNT_W'(1);
            rd_live_q <= 1'b1;
            rd_idx_q  <= scan_q[IDX_W-1:0];
          end else if (!rd_live_q) begin
            state_q <= S_EVICT;
          end
          if (rd_live_q && valid_q[rd_idx_q] &&
              (!best_ok_q || rd_data_q.count < best_cnt_q)) begin
            best_ok_q   <= 1'b1;
            best_idx_q  <= rd_idx_q;
            best_cnt_q  <= rd_data_q.count;
            best_key_q  <= rd_data_q.key;
            best_size_q <= rd_data_q.size;
          end
        end

        S_EVICT: begin
          if (out_free) begin
            valid_q[best_idx_q] <= 1'b0;
            total_q             <= total_evict;
            if (!free_ok_q || best_idx_q < free_idx_q) begin
              free_ok_q  <= 1'b1;
              free_idx_q <= best_idx_q;
            end
            out_vld_q   <= 1'b1;
            out_kind_q  <= KIND_EVICT;
            out_slot_q  <= SLOT_W'(best_idx_q);
            out_key_q   <= best_key_q;
            out_size_q  <= best_size_q;
            out_bytes_q <= total_evict;
            out_last_q  <= 1'b0;
            state_q     <= S_CHECK;
          end
        end

        S_STORE: begin
          if (out_free) begin
            valid_q[free_idx_q] <= 1'b1;
            total_q             <= total_store;
            out_vld_q   <= 1'b1;
            out_kind_q  <= KIND_STORE;
            out_slot_q  <= SLOT_W'(free_idx_q);
            out_key_q   <= key_q;
            out_size_q  <= vb_q;
            out_bytes_q <= total_store;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_evict_has_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVICT |-> best_ok_q)
    else $error("eviction without a chosen victim");

  a_store_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_STORE |-> free_ok_q)
    else $error("store without a free slot");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("second request taken while busy");

  a_evict_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_kind_q == KIND_EVICT |-> !out_last_q)
    else $error("eviction result marked last");

  a_bump_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && state_q == S_FOUND |-> hit_q && act_q == ACT_GET)
    else $error("count update without a get hit");

endmodule
